### rtl/bai_pkg.sv
// Shared constants, codes and control types for the bounded list engine.
`timescale 1ns / 1ps

package bai_pkg;

  // Storage size and the widths that follow from it.
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths of the request, result and configuration words.
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;
  localparam int CAP_W    = 5;

  // Common widths for comparing a position or capacity against the count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Request opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_UPDATE = 3'd4,
    OP_SEARCH = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADIX = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               shift_up;
    logic               shift_dn;
    logic               wr;
    logic [IDX_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   count;
  } cell_cmd_t;

  // Decoded outcome of one request, used to build the result word.
  typedef struct packed {
    status_t          status;
    logic             is_get;
    logic             is_search;
    logic             rd_invalid;
    logic [CNT_W-1:0] count_next;
  } ctrl_res_t;

endpackage

### rtl/bai_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps

// Request channel.
interface bai_req_if import bai_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

// Result channel.
interface bai_rsp_if import bai_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_value;
  logic                      found;
  logic [ECOUNT_W-1:0]       entry_count;

  modport source (output valid, status, read_value, found, entry_count, input ready);
  modport sink   (input valid, status, read_value, found, entry_count, output ready);
endinterface

// Configuration write channel.
interface bai_cfg_if import bai_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

### rtl/bounded_array_insert_delete_engine.sv
// Top level of the bounded list engine: cell chain, decoder and result register.
// A result is registered and shown in the cycle after its request is accepted.
// Throughput: one request per cycle while results are read; every operation, including
// an insert or delete shift and a search, is finished by the cell chain as it is taken.
// A new request is taken whenever the result register is empty or being read.
// Reset (rst, synchronous) empties the list, sets the capacity to 16 and drops
// any pending result; the stored entries themselves are not cleared.
`timescale 1ns / 1ps

module bounded_array_insert_delete_engine import bai_pkg::*; (
  input logic    clk,
  input logic    rst,
  bai_req_if.sink   req,
  bai_rsp_if.source rsp,
  bai_cfg_if.sink   cfg
);

  logic [CNT_W-1:0]   fill_count;
  logic [CAP_W-1:0]   capacity;
  logic               fire;
  cell_cmd_t          cmd;
  ctrl_res_t          res;
  logic [VALUE_W-1:0] cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [VALUE_W-1:0] rd_word;
  logic [VALUE_W-1:0] read_value_next;

  // Handshakes: the result register parts the two sides.
  assign req.ready = !rsp.valid || rsp.ready;
  assign cfg.ready = 1'b1;
  assign fire      = req.valid && req.ready;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.capacity_in_use;
    end
  end

  // Request decoder.
  bai_ctrl u_ctrl (
    .go         (fire),
    .opcode     (req.opcode),
    .position   (req.position),
    .value      (req.value),
    .fill_count (fill_count),
    .capacity   (capacity),
    .cmd        (cmd),
    .res        (res)
  );

  // Chain of cells, each wired to its two neighbors; the ends see themselves.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    bai_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == MAX_ENTRIES - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .match      (match[i])
    );
  end

  // Read port for get, and the word placed on the result.
  assign rd_word = cell_data[IDX_W'(req.position)];

  always_comb begin
    if (!res.is_get) begin
      read_value_next = '0;
    end else if (res.rd_invalid) begin
      read_value_next = '1;
    end else begin
      read_value_next = rd_word;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (fire) begin
      fill_count <= res.count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status      <= res.status;
      rsp.read_value  <= read_value_next;
      rsp.found       <= res.is_search && (|match);
      rsp.entry_count <= ECOUNT_W'(res.count_next);
    end
  end

endmodule

### rtl/bai_cell.sv
// One storage cell of the list chain: holds an entry, shifts and compares.
`timescale 1ns / 1ps

module bai_cell import bai_pkg::*; (
  input  logic               clk,
  input  logic [IDX_W-1:0]   cell_idx,
  input  cell_cmd_t          cmd,
  input  logic [VALUE_W-1:0] left_data,
  input  logic [VALUE_W-1:0] right_data,
  output logic [VALUE_W-1:0] data,
  output logic               match
);

  // The cell takes its left neighbor on an insert above the slot, the new
  // word at the slot itself, and its right neighbor on a delete from here up.
  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (cell_idx > cmd.pos) begin
        data <= left_data;
      end else if (cell_idx == cmd.pos) begin
        data <= cmd.value;
      end
    end else if (cmd.shift_dn) begin
      if (cell_idx >= cmd.pos) begin
        data <= right_data;
      end
    end else if (cmd.wr && (cell_idx == cmd.pos)) begin
      data <= cmd.value;
    end
  end

  // Only cells that hold a live entry take part in a search.
  assign match = (data == cmd.value) && (CNT_W'(cell_idx) < cmd.count);

endmodule

### rtl/bai_ctrl.sv
// Request decoder: checks bounds and builds the command for the cell chain.
`timescale 1ns / 1ps

module bai_ctrl import bai_pkg::*; (
  input  logic                go,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [POS_W-1:0]    position,
  input  logic [VALUE_W-1:0]  value,
  input  logic [CNT_W-1:0]    fill_count,
  input  logic [CAP_W-1:0]    capacity,
  output cell_cmd_t           cmd,
  output ctrl_res_t           res
);

  logic [CNT_W-1:0] limit;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  op_t              op;

  // The effective limit is the capacity clamped to the storage size.
  always_comb begin
    if (LIM_W'(capacity) > LIM_W'(MAX_ENTRIES)) begin
      limit = CNT_W'(MAX_ENTRIES);
    end else begin
      limit = CNT_W'(capacity);
    end
  end

  assign full  = (fill_count >= limit);
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(fill_count);
  assign op    = op_t'(opcode);

  // Decode the opcode; the chain only moves when the request is taken.
  always_comb begin
    cmd            = '0;
    cmd.pos        = IDX_W'(position);
    cmd.value      = value;
    cmd.count      = fill_count;
    res.status     = ST_OK;
    res.is_get     = 1'b0;
    res.is_search  = 1'b0;
    res.rd_invalid = 1'b0;
    res.count_next = fill_count;
    unique case (op)
      OP_APPEND: begin
        if (full) begin
          res.status = ST_OVER;
        end else begin
          cmd.wr         = go;
          cmd.pos        = IDX_W'(fill_count);
          res.count_next = fill_count + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          res.status = ST_OVER;
        end else if (pos_c > cnt_c) begin
          res.status = ST_BADIX;
        end else begin
          cmd.shift_up   = go;
          res.count_next = fill_count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (fill_count == '0) begin
          res.status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          res.status = ST_BADIX;
        end else begin
          cmd.shift_dn   = go;
          res.count_next = fill_count - CNT_W'(1);
        end
      end
      OP_GET: begin
        res.is_get = 1'b1;
        if (pos_c >= cnt_c) begin
          res.status     = ST_BADIX;
          res.rd_invalid = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (pos_c >= cnt_c) begin
          res.status = ST_BADIX;
        end else begin
          cmd.wr = go;
        end
      end
      OP_SEARCH: begin
        res.is_search = 1'b1;
      end
      default: begin
        // Unused opcodes do nothing and report ok.
      end
    endcase
  end

endmodule

### rtl/bai_checker.sv
// Port-level assertions for the bounded list engine, bound to the top level.
`timescale 1ns / 1ps

module bai_checker import bai_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [VALUE_W-1:0]  rsp_read_value,
  input logic                rsp_found,
  input logic [ECOUNT_W-1:0] rsp_entry_count
);

  // A shown result stays put until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_value) && $stable(rsp_found) && $stable(rsp_entry_count))
    else $error("result changed while stalled");

  // Every accepted request shows its result on the next cycle.
  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request produced no result");

  // The list never reports more entries than the storage holds.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_entry_count <= ECOUNT_W'(MAX_ENTRIES)))
    else $error("entry count above storage size");

  // A search hit is an ok result carrying no read word.
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> (rsp_status == ST_OK) && (rsp_read_value == '0))
    else $error("search hit with bad status or read word");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result shown after reset");

endmodule

bind bounded_array_insert_delete_engine bai_checker u_bai_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_value  (rsp.read_value),
  .rsp_found       (rsp.found),
  .rsp_entry_count (rsp.entry_count)
);

### tb/tb_top.sv
// Self-checking testbench for the bounded list engine: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
  import bai_pkg::*;

  typedef logic signed [VALUE_W-1:0] word_t;

  // One result of the list engine, as predicted or as typed into the table.
  typedef struct packed {
    status_t             status;
    word_t               rd;
    logic                found;
    logic [ECOUNT_W-1:0] cnt;
  } list_result_t;

  // One row of the directed table: a capacity write or a request.
  typedef struct packed {
    logic                is_cfg;
    logic [CAP_W-1:0]    cap;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    word_t               val;
    logic                typed;
    list_result_t        res;
  } stim_row_t;

  // Opcodes the engine treats as no operation.
  localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

  localparam word_t WORD_MAX      = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN      = 32'sh8000_0000;
  localparam word_t WORD_ALL_ONES = -32'sd1;

  localparam int HOLD_CYCLES = 50;

  logic clk = 1'b0;
  logic rst;

  bai_req_if req_ch ();
  bai_rsp_if rsp_ch ();
  bai_cfg_if cfg_ch ();

  bounded_array_insert_delete_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the list and its capacity register.
  word_t            shadow_words [MAX_ENTRIES];
  int               shadow_len = 0;
  logic [CAP_W-1:0] shadow_cap = CAP_RESET;

  list_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int           failures    = 0;
  int           holds_asked = 0;
  int           holds_done  = 0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the engine hangs.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  // Apply one request to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_op(logic [OPCODE_W-1:0] op,
                                                 logic [POS_W-1:0] pos, word_t val);
    list_result_t r;
    int           lim;
    int           i;
    r.status = ST_OK;
    r.rd     = '0;
    r.found  = 1'b0;
    lim = (shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_cap);
    case (op)
      OP_APPEND: begin
        if (shadow_len >= lim) begin
          r.status = ST_OVER;
        end else begin
          shadow_words[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // Overflow wins over a bad position.
        if (shadow_len >= lim) begin
          r.status = ST_OVER;
        end else if (int'(pos) > shadow_len) begin
          r.status = ST_BADIX;
        end else begin
          for (i = shadow_len; i > int'(pos); i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= shadow_len) begin
          r.status = ST_BADIX;
        end else begin
          for (i = int'(pos); i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      OP_GET: begin
        if (int'(pos) >= shadow_len) begin
          r.status = ST_BADIX;
          r.rd     = WORD_ALL_ONES;
        end else begin
          r.rd = shadow_words[pos];
        end
      end
      OP_UPDATE: begin
        if (int'(pos) >= shadow_len) r.status = ST_BADIX;
        else shadow_words[pos] = val;
      end
      OP_SEARCH: begin
        for (i = 0; i < shadow_len; i++) if (shadow_words[i] == val) r.found = 1'b1;
      end
      default: begin
      end
    endcase
    r.cnt = ECOUNT_W'(shadow_len);
    return r;
  endfunction

  function automatic stim_row_t req_row(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                        word_t val);
    stim_row_t row;
    row       = '0;
    row.op    = op;
    row.pos   = pos;
    row.val   = val;
    return row;
  endfunction

  function automatic stim_row_t chk_row(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                        word_t val, status_t st, word_t rd, logic fnd,
                                        logic [ECOUNT_W-1:0] cnt);
    stim_row_t row;
    row            = req_row(op, pos, val);
    row.typed      = 1'b1;
    row.res.status = st;
    row.res.rd     = rd;
    row.res.found  = fnd;
    row.res.cnt    = cnt;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CAP_W-1:0] cap);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.cap    = cap;
    return row;
  endfunction

  // Offer one request, record its expected result once taken, then maybe idle.
  task automatic issue_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos, word_t val,
                               logic typed, list_result_t typed_res);
    list_result_t predicted;
    int           r;
    int           gap;
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_list_op(op, pos, val);
    pending_results.push_back(typed ? typed_res : predicted);
    r = $urandom_range(0, 9);
    if (r < 6) gap = 0;
    else if (r < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 25);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Capacity is only changed once every outstanding result has come back.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_cap = cap;
    cfg_ch.valid <= 1'b0;
  endtask

  // Half random words, the rest extremes and values already in the list, so searches hit often.
  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return word_t'($urandom);
    if (r < 7 && shadow_len > 0) return shadow_words[$urandom_range(0, shadow_len - 1)];
    case ($urandom_range(0, 3))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return WORD_ALL_ONES;
      default: return '0;
    endcase
  endfunction

  // Random request; positions are mostly in range so the list actually moves.
  task automatic random_request(logic grow);
    int                  r;
    int                  app_end;
    int                  ins_end;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    app_end = grow ? 20 : 10;
    ins_end = grow ? 40 : 20;
    r = $urandom_range(0, 99);
    if (r < app_end) op = OP_APPEND;
    else if (r < ins_end) op = OP_INSERT;
    else if (r < 58) op = OP_DELETE;
    else if (r < 73) op = OP_GET;
    else if (r < 85) op = OP_UPDATE;
    else if (r < 97) op = OP_SEARCH;
    else op = r[0] ? OP_SPARE7 : OP_SPARE6;
    if ($urandom_range(0, 9) < 8) begin
      if (op == OP_INSERT) pos = POS_W'($urandom_range(0, shadow_len));
      else if (shadow_len > 0) pos = POS_W'($urandom_range(0, shadow_len - 1));
      else pos = '0;
    end else begin
      pos = POS_W'($urandom_range(0, 15));
    end
    issue_request(op, pos, pick_value(), 1'b0, '0);
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (rst === 1'b0 && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d read %0d count %0d",
                               rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.rd ||
            rsp_ch.found !== want.found || rsp_ch.entry_count !== want.cnt) begin
          note_failure($sformatf(
            "mismatch: want status %0d read %0d found %0d count %0d, got %0d %0d %0d %0d",
            want.status, want.rd, want.found, want.cnt, rsp_ch.status,
            rsp_ch.read_value, rsp_ch.found, rsp_ch.entry_count));
        end
      end
    end
  end

  // Result receiver: bursts of ready, short and long gaps, and long hold-offs on request.
  initial begin
    int r;
    int n;
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (holds_done != holds_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          rsp_ch.ready <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 9) begin
          rsp_ch.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          rsp_ch.ready <= 1'b0;
          n = $urandom_range(10, 30);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases at several capacities.
  initial begin
    int         phase_cap   [7] = '{16, 31, 4, 1, 0, 20, 9};
    bit         phase_grow  [7] = '{1, 1, 0, 1, 0, 1, 0};
    int         phase_items [7] = '{70, 60, 60, 50, 40, 60, 60};
    stim_row_t  row;
    int         p;
    int         k;

    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.opcode          <= '0;
    req_ch.position        <= '0;
    req_ch.value           <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.capacity_in_use <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list after reset: every read and removal is rejected.
    directed_rows.push_back(chk_row(OP_GET,    0, 0, ST_BADIX, WORD_ALL_ONES, 0, 0));
    directed_rows.push_back(chk_row(OP_DELETE, 0, 0, ST_EMPTY, 0, 0, 0));
    directed_rows.push_back(chk_row(OP_UPDATE, 3, 7, ST_BADIX, 0, 0, 0));
    directed_rows.push_back(chk_row(OP_SEARCH, 0, 0, ST_OK, 0, 0, 0));
    directed_rows.push_back(chk_row(OP_INSERT, 1, 5, ST_BADIX, 0, 0, 0));
    // Insert into the empty list at the head, then append.
    directed_rows.push_back(chk_row(OP_INSERT, 0, WORD_MAX, ST_OK, 0, 0, 1));
    directed_rows.push_back(chk_row(OP_APPEND, 0, WORD_MIN, ST_OK, 0, 0, 2));
    // Insert at the tail and in the middle, then read back, search, update, delete and try spare opcodes.
    directed_rows.push_back(req_row(OP_INSERT, 2, WORD_ALL_ONES));
    directed_rows.push_back(req_row(OP_INSERT, 1, 0));
    directed_rows.push_back(req_row(OP_GET, 0, 0));
    directed_rows.push_back(req_row(OP_GET, 3, 0));
    directed_rows.push_back(req_row(OP_GET, 4, 0));
    directed_rows.push_back(req_row(OP_SEARCH, 0, WORD_MIN));
    directed_rows.push_back(req_row(OP_SEARCH, 15, 32'sh0000_3039));
    directed_rows.push_back(req_row(OP_UPDATE, 3, 32'sh55AA_55AA));
    directed_rows.push_back(req_row(OP_DELETE, 0, 0));
    directed_rows.push_back(req_row(OP_DELETE, 15, 0));
    directed_rows.push_back(req_row(OP_SPARE6, 15, WORD_ALL_ONES));
    directed_rows.push_back(req_row(OP_SPARE7, 0, WORD_MAX));
    // Capacity lowered below the count: growth is refused, overflow before position.
    directed_rows.push_back(cfg_row(1));
    directed_rows.push_back(req_row(OP_APPEND, 0, 9));
    directed_rows.push_back(req_row(OP_INSERT, 15, 9));
    // Capacity zero: entries kept, still removable.
    directed_rows.push_back(cfg_row(0));
    directed_rows.push_back(req_row(OP_INSERT, 0, 1));
    directed_rows.push_back(req_row(OP_DELETE, 2, 0));
    // Capacity above the storage size is clamped.
    directed_rows.push_back(cfg_row(31));
    directed_rows.push_back(req_row(OP_APPEND, 0, WORD_MIN));
    directed_rows.push_back(req_row(OP_GET, 15, 0));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_capacity(row.cap);
      else issue_request(row.op, row.pos, row.val, row.typed, row.res);
    end

    // Random phases; two of them also get a long receiver hold-off mid-phase.
    for (p = 0; p < 7; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      for (k = 0; k < phase_items[p]; k++) begin
        if ((p == 0 || p == 3) && k == 30) holds_asked++;
        random_request(phase_grow[p]);
      end
    end

    // Drain and let any stray result show up.
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) note_failure("results still outstanding at the end");
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
